FILE: hdl/pesb_pkg.sv
// Shared types, constants and arithmetic helpers for the particle integrator.
// Used by the top level; the generic RAM does not depend on it.
`default_nettype none

package pesb_pkg;

  localparam int NUM_PARTICLES = 256;
  localparam int MAX_TRAIL     = 16;
  localparam int PID_W         = $clog2(NUM_PARTICLES);
  localparam int TRAIL_AW      = $clog2(MAX_TRAIL);
  localparam int CNT_W         = $clog2(MAX_TRAIL + 1);
  localparam int NUM_CFG       = 8;
  localparam int CFG_AW        = $clog2(NUM_CFG * 4);

  localparam logic [14:0] AREA_W_RST   = 15'd800;
  localparam logic [14:0] AREA_H_RST   = 15'd600;
  localparam logic [4:0]  TRAIL_LEN_RST = 5'd16;
  localparam logic [15:0] EDGE_MARGIN  = 16'd3;

  typedef enum logic [2:0] {
    REG_GRAVITY_X  = 3'd0,
    REG_GRAVITY_Y  = 3'd1,
    REG_AREA_W     = 3'd2,
    REG_AREA_H     = 3'd3,
    REG_TRAIL_DIST = 3'd4,
    REG_TRAIL_LEN  = 3'd5,
    REG_TRAIL_ON   = 3'd6,
    REG_WALLS_ON   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_GRAV,
    ST_MOVE,
    ST_POS,
    ST_WALL
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [TRAIL_AW-1:0] head;
    logic [31:0]         age;
    logic [7:0]          size;
    logic signed [23:0]  vel_y;
    logic signed [23:0]  vel_x;
    logic signed [23:0]  pos_y;
    logic signed [23:0]  pos_x;
  } particle_t;

  localparam int ENTRY_W = $bits(particle_t);

  // Rounds a Q.24 product to Q.8, half rounding upwards.
  function automatic logic signed [25:0] round_q8(input logic signed [40:0] p);
    logic signed [41:0] biased;
    biased = {p[40], p} + 42'sd32768;
    return biased[41:16];
  endfunction

  // Clamps a 27-bit signed value into the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v[26:23] == 4'b0000 || v[26:23] == 4'b1111) begin
      r = v[23:0];
    end else if (v[26]) begin
      r = 24'sh800000;
    end else begin
      r = 24'sh7FFFFF;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] neg_sat24(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v == 24'sh800000) begin
      r = 24'sh7FFFFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // Adds a rounded step onto a Q15.8 value with saturation.
  function automatic logic signed [23:0] add_step(input logic signed [23:0] a,
                                                  input logic signed [40:0] p);
    logic signed [25:0] r;
    r = round_q8(p);
    return sat24({{3{a[23]}}, a} + {r[25], r});
  endfunction

endpackage

`default_nettype wire

FILE: hdl/particle_euler_step_bounce_top.sv
// Particle table with Euler time step, trail recording and wall bounce.
// Depends on pesb_pkg and pesb_ram.
//
// Each particle lives in one row of a synchronous particle RAM; trail points
// live in a second RAM addressed by particle and slot. Requests are handled
// one at a time. A load passes through ST_LOAD, which writes its row and
// registers its result; a step runs through the states ST_READ to ST_WALL:
// particle read, gravity product, velocity update and trail distance,
// position product and squares, position update and trail write, then wall
// handling with write-back. The length of a step is set by the chain of two
// dependent multiplications between the particle RAM read and its
// write-back. A result that is still waiting holds the block in ST_LOAD or
// ST_WALL for as long as the stall lasts. Trail head and count are reset
// through one valid flip-flop per particle, so no clearing pass runs after
// reset. The result register lets a new request be taken while the previous
// result still waits.
`default_nettype none

module particle_euler_step_bounce_top
  import pesb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // slave side
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata from bit 0: particle_id(8) dt(16) load_pos_x(24) load_pos_y(24)
  //                   load_vel_x(24) load_vel_y(24) load_size(8)
  input  wire logic [127:0]       s_axis_tdata_i,
  // tuser: func(1)
  input  wire logic               s_axis_tuser_i,
  // master side
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // tdata from bit 0: pos_x(24) pos_y(24) vel_x(24) vel_y(24) age(32)
  //                   trail_len(5) trail_pushed(1) zero(2)
  output logic [135:0]            m_axis_tdata_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------- config
  logic signed [23:0] grav_x_q, grav_y_q;
  logic [14:0]        area_w_q, area_h_q;
  logic [31:0]        dist_thr_q;
  logic [4:0]         trail_len_q;
  logic               trail_on_q, walls_on_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q    <= '0;
      grav_y_q    <= '0;
      area_w_q    <= AREA_W_RST;
      area_h_q    <= AREA_H_RST;
      dist_thr_q  <= '0;
      trail_len_q <= TRAIL_LEN_RST;
      trail_on_q  <= 1'b0;
      walls_on_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRAVITY_X:  grav_x_q    <= pwdata[23:0];
        REG_GRAVITY_Y:  grav_y_q    <= pwdata[23:0];
        REG_AREA_W:     area_w_q    <= pwdata[14:0];
        REG_AREA_H:     area_h_q    <= pwdata[14:0];
        REG_TRAIL_DIST: dist_thr_q  <= pwdata;
        REG_TRAIL_LEN:  trail_len_q <= pwdata[4:0];
        REG_TRAIL_ON:   trail_on_q  <= pwdata[0];
        REG_WALLS_ON:   walls_on_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRAVITY_X:  prdata = {{8{grav_x_q[23]}}, grav_x_q};
      REG_GRAVITY_Y:  prdata = {{8{grav_y_q[23]}}, grav_y_q};
      REG_AREA_W:     prdata = {17'd0, area_w_q};
      REG_AREA_H:     prdata = {17'd0, area_h_q};
      REG_TRAIL_DIST: prdata = dist_thr_q;
      REG_TRAIL_LEN:  prdata = {27'd0, trail_len_q};
      REG_TRAIL_ON:   prdata = {31'd0, trail_on_q};
      REG_WALLS_ON:   prdata = {31'd0, walls_on_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- request
  logic [PID_W-1:0]   id_q;
  logic [15:0]        dt_q;
  logic signed [23:0] ld_px_q, ld_py_q, ld_vx_q, ld_vy_q;
  logic [7:0]         ld_size_q;

  // ---------------------------------------------------------------- control
  state_e state_q, state_d;
  logic   in_fire, done_fire, out_free;
  logic   m_valid_q;
  logic [NUM_PARTICLES-1:0] valid_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    done_fire = 1'b0;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_fire) begin
          state_d = s_axis_tuser_i ? ST_READ : ST_LOAD;
        end
      end
      ST_READ: state_d = ST_GRAV;
      ST_GRAV: state_d = ST_MOVE;
      ST_MOVE: state_d = ST_POS;
      ST_POS:  state_d = ST_WALL;
      ST_LOAD, ST_WALL: begin
        if (out_free) begin
          done_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q <= state_d;
      if (done_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (done_fire && (state_q == ST_LOAD)) begin
        valid_q[id_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q      <= s_axis_tdata_i[PID_W-1:0];
      dt_q      <= s_axis_tdata_i[23:8];
      ld_px_q   <= s_axis_tdata_i[47:24];
      ld_py_q   <= s_axis_tdata_i[71:48];
      ld_vx_q   <= s_axis_tdata_i[95:72];
      ld_vy_q   <= s_axis_tdata_i[119:96];
      ld_size_q <= s_axis_tdata_i[127:120];
    end
  end

  // ---------------------------------------------------------------- memories
  particle_t p_rd, p_rd_eff, p_wr, ent_q;
  logic [ENTRY_W-1:0] p_rd_raw;
  logic [47:0]        tp_rd;
  logic               tp_we;
  logic [TRAIL_AW-1:0] head_dec;
  logic [PID_W+TRAIL_AW-1:0] tp_raddr;

  pesb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PARTICLES)
  ) u_particle_ram (
    .clk_i   (clk_i),
    .we_i    (done_fire),
    .waddr_i (id_q),
    .wdata_i (p_wr),
    .raddr_i (s_axis_tdata_i[PID_W-1:0]),
    .rdata_o (p_rd_raw)
  );

  assign p_rd = particle_t'(p_rd_raw);

  // A particle never loaded since reset has an empty trail with head zero.
  always_comb begin
    p_rd_eff = p_rd;
    if (!valid_q[id_q]) begin
      p_rd_eff.head  = '0;
      p_rd_eff.count = '0;
    end
  end

  assign tp_raddr = {id_q, p_rd_eff.head};

  pesb_ram #(
    .WIDTH (48),
    .DEPTH (NUM_PARTICLES * MAX_TRAIL)
  ) u_trail_ram (
    .clk_i   (clk_i),
    .we_i    (tp_we),
    .waddr_i ({id_q, head_dec}),
    .wdata_i ({ent_q.pos_y, ent_q.pos_x}),
    .raddr_i (tp_raddr),
    .rdata_o (tp_rd)
  );

  // ---------------------------------------------------------------- datapath
  logic [31:0]        age_q;
  logic signed [40:0] gprod_x_q, gprod_y_q, vprod_x_q, vprod_y_q;
  logic signed [23:0] vx_q, vy_q, npx_q, npy_q;
  logic signed [24:0] dx_q, dy_q;
  logic [48:0]        d2x_q, d2y_q;
  logic [TRAIL_AW-1:0] head_n_q;
  logic [CNT_W-1:0]   cnt_n_q;
  logic               pushed_q;

  logic [32:0]        age_sum;
  logic signed [49:0] sq_x, sq_y;
  logic [49:0]        d2_sum;
  logic               take;
  logic [CNT_W:0]     lim, cnt_inc, cnt_new;

  assign age_sum = {1'b0, p_rd.age} + {17'd0, dt_q};
  assign sq_x    = dx_q * dx_q;
  assign sq_y    = dy_q * dy_q;
  assign d2_sum  = {1'b0, d2x_q} + {1'b0, d2y_q};
  assign head_dec = (ent_q.head == '0) ? TRAIL_AW'(MAX_TRAIL - 1) : ent_q.head - 1'b1;

  always_comb begin
    if (trail_len_q == 5'd0) begin
      lim = (CNT_W + 1)'(1);
    end else if (int'(trail_len_q) > MAX_TRAIL) begin
      lim = (CNT_W + 1)'(MAX_TRAIL);
    end else begin
      lim = (CNT_W + 1)'(trail_len_q);
    end
    cnt_inc = {1'b0, ent_q.count} + 1'b1;
    cnt_new = (cnt_inc > lim) ? cnt_inc - 1'b1 : cnt_inc;
    if (int'(cnt_new) > MAX_TRAIL) begin
      cnt_new = (CNT_W + 1)'(MAX_TRAIL);
    end
    take = trail_on_q & ((ent_q.count == '0) | (d2_sum > {18'd0, dist_thr_q}));
  end

  assign tp_we = (state_q == ST_POS) & take;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_READ: begin
        ent_q     <= p_rd_eff;
        age_q     <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
        gprod_x_q <= grav_x_q * $signed({1'b0, dt_q});
        gprod_y_q <= grav_y_q * $signed({1'b0, dt_q});
      end
      ST_GRAV: begin
        vx_q <= add_step(ent_q.vel_x, gprod_x_q);
        vy_q <= add_step(ent_q.vel_y, gprod_y_q);
        dx_q <= {ent_q.pos_x[23], ent_q.pos_x} - {tp_rd[23], tp_rd[23:0]};
        dy_q <= {ent_q.pos_y[23], ent_q.pos_y} - {tp_rd[47], tp_rd[47:24]};
      end
      ST_MOVE: begin
        vprod_x_q <= vx_q * $signed({1'b0, dt_q});
        vprod_y_q <= vy_q * $signed({1'b0, dt_q});
        d2x_q     <= sq_x[48:0];
        d2y_q     <= sq_y[48:0];
      end
      ST_POS: begin
        npx_q    <= add_step(ent_q.pos_x, vprod_x_q);
        npy_q    <= add_step(ent_q.pos_y, vprod_y_q);
        head_n_q <= take ? head_dec : ent_q.head;
        pushed_q <= take;
        if (!trail_on_q) begin
          cnt_n_q <= '0;
        end else if (take) begin
          cnt_n_q <= cnt_new[CNT_W-1:0];
        end else begin
          cnt_n_q <= ent_q.count;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- walls
  logic signed [25:0] half, wx, wy, ox, oy, wx_in, wy_in;
  logic               hit_r, hit_l, hit_t, hit_b;
  logic signed [23:0] fpx, fpy, fvx, fvy, vx_1, vy_1;

  always_comb begin
    half  = $signed({10'd0, {1'b0, ent_q.size, 7'd0} + EDGE_MARGIN});
    wx    = $signed({3'd0, area_w_q, 8'd0});
    wy    = $signed({3'd0, area_h_q, 8'd0});
    ox    = {{2{npx_q[23]}}, npx_q};
    oy    = {{2{npy_q[23]}}, npy_q};
    wx_in = wx - half;
    wy_in = wy - half;
    hit_r = walls_on_q & (ox + half >= wx);
    hit_l = walls_on_q & (ox <= half);
    hit_t = walls_on_q & (oy <= half);
    hit_b = walls_on_q & (oy + half >= wy);

    // Each firing test reflects once, so opposite walls on one axis reflect twice.
    vx_1 = hit_r ? neg_sat24(vx_q) : vx_q;
    fvx  = hit_l ? neg_sat24(vx_1) : vx_1;
    vy_1 = hit_t ? neg_sat24(vy_q) : vy_q;
    fvy  = hit_b ? neg_sat24(vy_1) : vy_1;

    if (hit_l) begin
      fpx = half[23:0];
    end else if (hit_r) begin
      fpx = wx_in[23:0];
    end else begin
      fpx = npx_q;
    end
    if (hit_b) begin
      fpy = wy_in[23:0];
    end else if (hit_t) begin
      fpy = half[23:0];
    end else begin
      fpy = npy_q;
    end
  end

  // ---------------------------------------------------------------- write-back
  always_comb begin
    if (state_q == ST_LOAD) begin
      p_wr.pos_x = ld_px_q;
      p_wr.pos_y = ld_py_q;
      p_wr.vel_x = ld_vx_q;
      p_wr.vel_y = ld_vy_q;
      p_wr.size  = ld_size_q;
      p_wr.age   = '0;
      p_wr.head  = '0;
      p_wr.count = '0;
    end else begin
      p_wr.pos_x = fpx;
      p_wr.pos_y = fpy;
      p_wr.vel_x = fvx;
      p_wr.vel_y = fvy;
      p_wr.size  = ent_q.size;
      p_wr.age   = age_q;
      p_wr.head  = head_n_q;
      p_wr.count = cnt_n_q;
    end
  end

  logic [135:0] out_q;

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_q <= {2'b00,
                (state_q == ST_WALL) & pushed_q,
                5'(p_wr.count),
                p_wr.age,
                p_wr.vel_y, p_wr.vel_x,
                p_wr.pos_y, p_wr.pos_x};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/pesb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module pesb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
